// ----- hw/rtl/chs_pkg.sv -----
package chs_pkg;

    // Q1.14 component
    typedef logic signed [15:0] q14_t;

    // three-axis basis, tangent x in the low bits
    typedef struct packed {
        q14_t bz;
        q14_t by;
        q14_t bx;
        q14_t nz;
        q14_t ny;
        q14_t nx;
        q14_t tz;
        q14_t ty;
        q14_t tx;
    } basis_t;

    localparam int MAX_ITER = 24;
    localparam int CW       = 34;   // CORDIC x/y width
    localparam int ZW       = 32;   // CORDIC angle width
    localparam int XW       = 33;   // disk point width (Q30)
    localparam int W_W      = 26;   // mapped vector component (Q20)
    localparam int LEN_W    = 27;   // length root width
    localparam int NUM_W    = 41;   // divider numerator width
    localparam int QB       = 15;   // quotient bits

    typedef logic signed [W_W-1:0] wcomp_t;

    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'h26DD3B6A;
    localparam logic [30:0] HALF_PI_Q30     = 31'h6487ED51;

    localparam logic [29:0] ATAN_Q30 [MAX_ITER] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
    };

endpackage

// ----- hw/rtl/cosine_hemisphere_sampler_top.sv -----
// Cosine-weighted hemisphere sampler. Each input beat carries two uniform
// numbers u, v (unsigned Q0.16) and a tangent/normal/bitangent basis (signed
// Q1.14); each output beat carries the normalized direction (signed Q1.14)
// x*T + y*N + z*B, with the disk point at angle 2*pi*u and radius sqrt(v) and
// the height y = sqrt(1 - x^2 - z^2). A basis that maps to a zero-length
// vector gives an all-zero direction. The datapath is a single stalling
// pipeline: one beat per clock in and out when m_tready stays high. Its
// stages include the CORDIC stages (one per iteration, capped at 24), three
// digit-by-digit square roots (30, 31 and 27 stages) and a 15-stage divider.
// Back-pressure on m_tready freezes the whole pipeline; s_tready drops only
// while a result sits in the output register and is not taken.
module cosine_hemisphere_sampler_top import chs_pkg::*; #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rand_u, rand_v, tangent_x/y/z, normal_x/y/z, bitangent_x/y/z (16b each)
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // dir_x, dir_y, dir_z (16b each)
    output logic [47:0]  m_tdata
);
    localparam int STEPS  = (ANGLE_ITERATIONS > MAX_ITER) ? MAX_ITER : ANGLE_ITERATIONS;
    localparam int BAS_W  = $bits(basis_t);
    localparam int CSIDE  = 16 + BAS_W;          // v and basis through CORDIC
    localparam int RSIDE  = 2 * CW + BAS_W;      // cos, sin, basis through radius root
    localparam int HSIDE  = 2 * XW + BAS_W;      // x, z, basis through height root
    localparam int LSIDE  = 3 * W_W;             // w through length root

    // global advance: the pipeline moves unless the output beat is stuck
    logic en;
    assign en       = ~m_tvalid | m_tready;
    assign s_tready = en;

    // ---------------- sin/cos of 2*pi*u ----------------
    logic                 c_vld;
    logic signed [CW-1:0] c_cos;
    logic signed [CW-1:0] c_sin;
    logic [CSIDE-1:0]     c_side;

    chs_cordic #(
        .ITERS  (STEPS),
        .SIDE_W (CSIDE)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_u      (s_tdata[15:0]),
        .in_side   (s_tdata[175:16]),
        .out_valid (c_vld),
        .out_cos   (c_cos),
        .out_sin   (c_sin),
        .out_side  (c_side)
    );

    // ---------------- radius = sqrt(v) in Q30 ----------------
    logic             r_vld;
    logic [29:0]      r_root;
    logic [RSIDE-1:0] r_side;

    chs_isqrt #(
        .RAD_W  (60),
        .SIDE_W (RSIDE)
    ) u_rad_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_vld),
        .in_rad    ({c_side[15:0], 44'b0}),
        .in_side   ({c_cos, c_sin, c_side[CSIDE-1:16]}),
        .out_valid (r_vld),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    logic signed [CW-1:0] r_cos;
    logic signed [CW-1:0] r_sin;
    assign r_cos = $signed(r_side[RSIDE-1 -: CW]);
    assign r_sin = $signed(r_side[RSIDE-CW-1 -: CW]);

    // M1: disk point x = rad*cos, z = rad*sin (floor shift 30)
    logic                 m1_vld_reg;
    logic signed [XW-1:0] m1_x_reg;
    logic signed [XW-1:0] m1_z_reg;
    basis_t               m1_bas_reg;
    logic signed [64:0]   px;
    logic signed [64:0]   pz;

    assign px = $signed({1'b0, r_root}) * r_cos;
    assign pz = $signed({1'b0, r_root}) * r_sin;

    // M2: squares
    logic                 m2_vld_reg;
    logic signed [XW-1:0] m2_x_reg;
    logic signed [XW-1:0] m2_z_reg;
    logic [61:0]          m2_xx_reg;
    logic [61:0]          m2_zz_reg;
    basis_t               m2_bas_reg;
    logic signed [65:0]   sqx;
    logic signed [65:0]   sqz;

    assign sqx = m1_x_reg * m1_x_reg;
    assign sqz = m1_z_reg * m1_z_reg;

    // M3: t = 1 - x^2 - z^2 (Q60), clamped at zero
    logic                 m3_vld_reg;
    logic signed [XW-1:0] m3_x_reg;
    logic signed [XW-1:0] m3_z_reg;
    logic [61:0]          m3_t_reg;
    basis_t               m3_bas_reg;
    logic signed [63:0]   tw;

    assign tw = $signed(64'h1000_0000_0000_0000) - $signed({2'b00, m2_xx_reg})
              - $signed({2'b00, m2_zz_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
        end else if (en) begin
            m1_vld_reg <= r_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_x_reg   <= $signed(px[62:30]);
            m1_z_reg   <= $signed(pz[62:30]);
            m1_bas_reg <= basis_t'(r_side[BAS_W-1:0]);
            m2_x_reg   <= m1_x_reg;
            m2_z_reg   <= m1_z_reg;
            m2_xx_reg  <= sqx[61:0];
            m2_zz_reg  <= sqz[61:0];
            m2_bas_reg <= m1_bas_reg;
            m3_x_reg   <= m2_x_reg;
            m3_z_reg   <= m2_z_reg;
            m3_t_reg   <= tw[63] ? '0 : tw[61:0];
            m3_bas_reg <= m2_bas_reg;
        end
    end

    // ---------------- height y = sqrt(t) ----------------
    logic             h_vld;
    logic [30:0]      h_root;
    logic [HSIDE-1:0] h_side;

    chs_isqrt #(
        .RAD_W  (62),
        .SIDE_W (HSIDE)
    ) u_hgt_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m3_vld_reg),
        .in_rad    (m3_t_reg),
        .in_side   ({m3_x_reg, m3_z_reg, m3_bas_reg}),
        .out_valid (h_vld),
        .out_root  (h_root),
        .out_side  (h_side)
    );

    logic signed [XW-1:0] h_x;
    logic signed [XW-1:0] h_z;
    logic signed [XW-1:0] h_y;
    basis_t               h_bas;
    assign h_x   = $signed(h_side[HSIDE-1 -: XW]);
    assign h_z   = $signed(h_side[HSIDE-XW-1 -: XW]);
    assign h_y   = $signed({2'b00, h_root});
    assign h_bas = basis_t'(h_side[BAS_W-1:0]);

    // P: nine basis products, Q44; lane k = output axis, j = T, N, B
    q14_t coef [3][3];
    assign coef[0][0] = h_bas.tx;
    assign coef[1][0] = h_bas.ty;
    assign coef[2][0] = h_bas.tz;
    assign coef[0][1] = h_bas.nx;
    assign coef[1][1] = h_bas.ny;
    assign coef[2][1] = h_bas.nz;
    assign coef[0][2] = h_bas.bx;
    assign coef[1][2] = h_bas.by;
    assign coef[2][2] = h_bas.bz;

    logic               p_vld_reg;
    logic signed [48:0] p_prod_reg [3][3];
    logic signed [48:0] prod_next  [3][3];

    for (genvar k = 0; k < 3; k++) begin : g_prod
        assign prod_next[k][0] = coef[k][0] * h_x;
        assign prod_next[k][1] = coef[k][1] * h_y;
        assign prod_next[k][2] = coef[k][2] * h_z;
    end

    // S: sum and floor shift to Q20
    logic               s_vld_reg;
    wcomp_t             s_w_reg   [3];
    logic signed [50:0] acc       [3];

    for (genvar k = 0; k < 3; k++) begin : g_acc
        assign acc[k] = p_prod_reg[k][0] + p_prod_reg[k][1] + p_prod_reg[k][2];
    end

    // Q: squares of w;  L: their sum
    logic               q_vld_reg;
    wcomp_t             q_w_reg   [3];
    logic [51:0]        q_sq_reg  [3];
    logic signed [51:0] sq_next   [3];

    for (genvar k = 0; k < 3; k++) begin : g_sq
        assign sq_next[k] = s_w_reg[k] * s_w_reg[k];
    end

    logic               l_vld_reg;
    wcomp_t             l_w_reg   [3];
    logic [53:0]        l_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            l_vld_reg <= 1'b0;
        end else if (en) begin
            p_vld_reg <= h_vld;
            s_vld_reg <= p_vld_reg;
            q_vld_reg <= s_vld_reg;
            l_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_prod_reg <= prod_next;
            for (int k = 0; k < 3; k++) begin
                s_w_reg[k]  <= $signed(acc[k][49:24]);
                q_w_reg[k]  <= s_w_reg[k];
                q_sq_reg[k] <= sq_next[k][51:0];
            end
            l_w_reg   <= q_w_reg;
            l_sum_reg <= 54'(q_sq_reg[0]) + 54'(q_sq_reg[1]) + 54'(q_sq_reg[2]);
        end
    end

    // ---------------- length = sqrt(|w|^2), Q20 ----------------
    logic             n_vld;
    logic [26:0]      n_root;
    logic [LSIDE-1:0] n_side;

    chs_isqrt #(
        .RAD_W  (54),
        .SIDE_W (LSIDE)
    ) u_len_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (l_vld_reg),
        .in_rad    (l_sum_reg),
        .in_side   ({l_w_reg[2], l_w_reg[1], l_w_reg[0]}),
        .out_valid (n_vld),
        .out_root  (n_root),
        .out_side  (n_side)
    );

    wcomp_t n_w [3];
    for (genvar k = 0; k < 3; k++) begin : g_nw
        assign n_w[k] = $signed(n_side[k*W_W +: W_W]);
    end

    // ---------------- rounded divide to Q14 ----------------
    logic d_vld;
    q14_t d_dir [3];

    chs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n_vld),
        .in_w      (n_w),
        .in_len    (LEN_W'(n_root)),
        .out_valid (d_vld),
        .out_dir   (d_dir)
    );

    // output register
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= d_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {d_dir[2], d_dir[1], d_dir[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/chs_isqrt.sv -----
module chs_isqrt import chs_pkg::*; #(
    parameter int RAD_W  = 60,
    parameter int SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]    out_side
);
    // one root bit per stage, restoring digit recurrence
    localparam int NSTG  = RAD_W / 2;
    localparam int REM_W = NSTG + 3;

    logic [NSTG-1:0]   vld_reg;
    logic [REM_W-1:0]  rem_reg  [NSTG];
    logic [NSTG-1:0]   root_reg [NSTG];
    logic [RAD_W-1:0]  rad_reg  [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];

    logic [NSTG-1:0]   vld_next;
    logic [REM_W-1:0]  rem_next  [NSTG];
    logic [NSTG-1:0]   root_next [NSTG];
    logic [RAD_W-1:0]  rad_next  [NSTG];
    logic [SIDE_W-1:0] side_next [NSTG];

    for (genvar j = 0; j < NSTG; j++) begin : g_stg
        logic              vld_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [NSTG-1:0]   root_prev;
        logic [RAD_W-1:0]  rad_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              fits;

        if (j == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = in_rad;
            assign side_prev = in_side;
        end else begin : g_rest
            assign vld_prev  = vld_reg[j-1];
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign rad_prev  = rad_reg[j-1];
            assign side_prev = side_reg[j-1];
        end

        assign rem_sh       = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
        assign trial        = REM_W'({root_prev, 2'b01});
        assign fits         = (rem_sh >= trial);
        assign vld_next[j]  = vld_prev;
        assign rem_next[j]  = fits ? (rem_sh - trial) : rem_sh;
        assign root_next[j] = {root_prev[NSTG-2:0], fits};
        assign rad_next[j]  = rad_prev << 2;
        assign side_next[j] = side_prev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NSTG; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_root  = root_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

// ----- hw/rtl/chs_cordic.sv -----
module chs_cordic import chs_pkg::*; #(
    parameter int ITERS  = 16,
    parameter int SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [15:0]          in_u,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_cos,
    output logic signed [CW-1:0] out_sin,
    output logic [SIDE_W-1:0]    out_side
);
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // angle stage: residual * pi/2, Q30
    logic              a_vld_reg;
    logic [ZW-1:0]     a_z_reg;
    logic [1:0]        a_quad_reg;
    logic [SIDE_W-1:0] a_side_reg;
    logic [44:0]       ang_prod;

    assign ang_prod = 45'(in_u[13:0]) * 45'(HALF_PI_Q30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_z_reg    <= {1'b0, ang_prod[44:14]};
            a_quad_reg <= in_u[15:14];
            a_side_reg <= in_side;
        end
    end

    // rotation stages
    logic [ITERS-1:0]        vld_reg;
    logic signed [CW-1:0]    x_reg    [ITERS];
    logic signed [CW-1:0]    y_reg    [ITERS];
    logic signed [ZW-1:0]    z_reg    [ITERS];
    logic [1:0]              quad_reg [ITERS];
    logic [SIDE_W-1:0]       side_reg [ITERS];

    logic [ITERS-1:0]        vld_next;
    logic signed [CW-1:0]    x_next    [ITERS];
    logic signed [CW-1:0]    y_next    [ITERS];
    logic signed [ZW-1:0]    z_next    [ITERS];
    logic [1:0]              quad_next [ITERS];
    logic [SIDE_W-1:0]       side_next [ITERS];

    for (genvar i = 0; i < ITERS; i++) begin : g_rot
        logic                 vld_prev;
        logic signed [CW-1:0] x_prev;
        logic signed [CW-1:0] y_prev;
        logic signed [ZW-1:0] z_prev;
        logic [1:0]           quad_prev;
        logic [SIDE_W-1:0]    side_prev;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] da;
        logic                 pos;

        if (i == 0) begin : g_first
            assign vld_prev  = a_vld_reg;
            assign x_prev    = $signed(CW'(CORDIC_GAIN_Q30));
            assign y_prev    = '0;
            assign z_prev    = $signed(a_z_reg);
            assign quad_prev = a_quad_reg;
            assign side_prev = a_side_reg;
        end else begin : g_rest
            assign vld_prev  = vld_reg[i-1];
            assign x_prev    = x_reg[i-1];
            assign y_prev    = y_reg[i-1];
            assign z_prev    = z_reg[i-1];
            assign quad_prev = quad_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign dx  = y_prev >>> i;
        assign dy  = x_prev >>> i;
        assign da  = $signed(ZW'(ATAN_Q30[i]));
        assign pos = ~z_prev[ZW-1];

        assign vld_next[i]  = vld_prev;
        assign x_next[i]    = pos ? (x_prev - dx) : (x_prev + dx);
        assign y_next[i]    = pos ? (y_prev + dy) : (y_prev - dy);
        assign z_next[i]    = pos ? (z_prev - da) : (z_prev + da);
        assign quad_next[i] = quad_prev;
        assign side_next[i] = side_prev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ITERS; k++) begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                quad_reg[k] <= quad_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    // exact quadrant rotation
    logic                 o_vld_reg;
    logic signed [CW-1:0] o_cos_reg;
    logic signed [CW-1:0] o_sin_reg;
    logic [SIDE_W-1:0]    o_side_reg;
    logic signed [CW-1:0] cos_next;
    logic signed [CW-1:0] sin_next;

    always_comb begin
        case (quad_reg[ITERS-1])
            QUAD_0: begin
                cos_next = x_reg[ITERS-1];
                sin_next = y_reg[ITERS-1];
            end
            QUAD_1: begin
                cos_next = -y_reg[ITERS-1];
                sin_next = x_reg[ITERS-1];
            end
            QUAD_2: begin
                cos_next = -x_reg[ITERS-1];
                sin_next = -y_reg[ITERS-1];
            end
            default: begin
                cos_next = y_reg[ITERS-1];
                sin_next = -x_reg[ITERS-1];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (en) begin
            o_vld_reg <= vld_reg[ITERS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_cos_reg  <= cos_next;
            o_sin_reg  <= sin_next;
            o_side_reg <= side_reg[ITERS-1];
        end
    end

    assign out_valid = o_vld_reg;
    assign out_cos   = o_cos_reg;
    assign out_sin   = o_sin_reg;
    assign out_side  = o_side_reg;

endmodule

// ----- hw/rtl/chs_div.sv -----
module chs_div import chs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  wcomp_t           in_w [3],
    input  logic [LEN_W-1:0] in_len,
    output logic             out_valid,
    output q14_t             out_dir [3]
);
    // prep: num = |w|*2^14 + len/2, so num < len*2^15 and the quotient fits QB bits
    logic             p_vld_reg;
    logic [NUM_W-1:0] p_num_reg [3];
    logic [LEN_W-1:0] p_den_reg;
    logic [2:0]       p_neg_reg;
    logic             p_zero_reg;
    logic [NUM_W-1:0] num_next  [3];

    for (genvar l = 0; l < 3; l++) begin : g_prep
        logic [W_W-1:0] mag;
        assign mag         = in_w[l][W_W-1] ? W_W'(-in_w[l]) : W_W'(in_w[l]);
        assign num_next[l] = NUM_W'({mag, 14'b0}) + NUM_W'(in_len >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else if (en) begin
            p_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                p_num_reg[l] <= num_next[l];
                p_neg_reg[l] <= in_w[l][W_W-1];
            end
            p_den_reg  <= in_len;
            p_zero_reg <= (in_len == '0);
        end
    end

    // one quotient bit per stage, three lanes
    logic [QB-1:0]    vld_reg;
    logic [NUM_W-1:0] rem_reg  [QB][3];
    logic [QB-1:0]    q_reg    [QB][3];
    logic [LEN_W-1:0] den_reg  [QB];
    logic [2:0]       neg_reg  [QB];
    logic             zero_reg [QB];

    logic [QB-1:0]    vld_next;
    logic [NUM_W-1:0] rem_next [QB][3];
    logic [QB-1:0]    q_next   [QB][3];
    logic [LEN_W-1:0] den_next [QB];
    logic [2:0]       neg_next [QB];
    logic             zero_next [QB];

    for (genvar s = 0; s < QB; s++) begin : g_stg
        logic             vld_prev;
        logic [NUM_W-1:0] rem_prev [3];
        logic [QB-1:0]    q_prev   [3];
        logic [LEN_W-1:0] den_prev;
        logic [2:0]       neg_prev;
        logic             zero_prev;
        logic [NUM_W-1:0] cmp;

        if (s == 0) begin : g_first
            assign vld_prev  = p_vld_reg;
            assign rem_prev  = p_num_reg;
            assign q_prev    = '{default: '0};
            assign den_prev  = p_den_reg;
            assign neg_prev  = p_neg_reg;
            assign zero_prev = p_zero_reg;
        end else begin : g_rest
            assign vld_prev  = vld_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign q_prev    = q_reg[s-1];
            assign den_prev  = den_reg[s-1];
            assign neg_prev  = neg_reg[s-1];
            assign zero_prev = zero_reg[s-1];
        end

        assign cmp = NUM_W'(den_prev) << (QB - 1 - s);

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic fits;
            assign fits           = (rem_prev[l] >= cmp);
            assign rem_next[s][l] = fits ? (rem_prev[l] - cmp) : rem_prev[l];
            assign q_next[s][l]   = {q_prev[l][QB-2:0], fits};
        end

        assign vld_next[s]  = vld_prev;
        assign den_next[s]  = den_prev;
        assign neg_next[s]  = neg_prev;
        assign zero_next[s] = zero_prev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QB; k++) begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                den_reg[k]  <= den_next[k];
                neg_reg[k]  <= neg_next[k];
                zero_reg[k] <= zero_next[k];
            end
        end
    end

    // sign restore; |w| <= len keeps q <= 2^14, so no saturation is reached
    logic o_vld_reg;
    q14_t o_dir_reg  [3];
    q14_t dir_next   [3];

    for (genvar l = 0; l < 3; l++) begin : g_out
        logic [15:0] qe;
        assign qe = 16'(q_reg[QB-1][l]);
        assign dir_next[l] = zero_reg[QB-1] ? '0 :
                             (neg_reg[QB-1][l] ? $signed(-qe) : $signed(qe));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (en) begin
            o_vld_reg <= vld_reg[QB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_dir_reg <= dir_next;
        end
    end

    assign out_valid = o_vld_reg;
    assign out_dir   = o_dir_reg;

endmodule

// ----- verif/cosine_hemisphere_sampler_top_test.sv -----
`timescale 1ns / 100ps

module cosine_hemisphere_sampler_top_test;
    import chs_pkg::*;

    localparam int ITER      = 16;
    localparam int LATENCY   = ITER + 115;
    localparam int STALL_MAX = 20000;

    // CORDIC arctangent table, Q30 radians
    localparam longint ATAN_TBL [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    typedef struct packed {
        q14_t dz;
        q14_t dy;
        q14_t dx;
    } dir_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;

    dir_t expected_dirs[$];
    int   error_count = 0;
    int   send_idle_pct = 0;   // sender idle chance, percent
    int   recv_stall_pct = 0;  // receiver stall chance, percent
    int   quiet_cycles = 0;

    always #1 aclk = ~aclk;

    cosine_hemisphere_sampler_top #(.ANGLE_ITERATIONS(ITER)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // ---------------- predictor ----------------
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic q14_t scale_to_q14(longint w, longint unsigned len);
        longint unsigned mag, q;
        longint r;
        mag = (w < 0) ? -w : w;
        q = ((mag << 14) + len / 2) / len;
        if (q > 32768) q = 32768;
        r = (w < 0) ? -longint'(q) : longint'(q);
        if (r > 32767) r = 32767;
        return q14_t'(r);
    endfunction

    function automatic dir_t sample_direction(logic [15:0] u, logic [15:0] v, basis_t b);
        longint cx, cy, ang, cs, sn, rad, px, pz, t, ht, dx, dy;
        longint w[3];
        longint tv[3], nv[3], bv[3];
        longint unsigned len;
        dir_t d;
        cx = 64'h26DD3B6A;
        cy = 0;
        ang = (longint'(u[13:0]) * 64'h6487ED51) >>> 14;
        for (int i = 0; i < ITER && i < 24; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (ang >= 0) begin
                cx -= dx; cy += dy; ang -= ATAN_TBL[i];
            end else begin
                cx += dx; cy -= dy; ang += ATAN_TBL[i];
            end
        end
        case (u[15:14])
            2'd0: begin cs = cx;  sn = cy;  end
            2'd1: begin cs = -cy; sn = cx;  end
            2'd2: begin cs = -cx; sn = -cy; end
            default: begin cs = cy; sn = -cx; end
        endcase
        rad = longint'(int_sqrt(longint'(v) << 44));
        px = floor_shift(rad * cs, 30);
        pz = floor_shift(rad * sn, 30);
        t = (64'sd1 <<< 60) - px * px - pz * pz;
        if (t < 0) t = 0;
        ht = longint'(int_sqrt(t));
        tv = '{b.tx, b.ty, b.tz};
        nv = '{b.nx, b.ny, b.nz};
        bv = '{b.bx, b.by, b.bz};
        for (int k = 0; k < 3; k++)
            w[k] = floor_shift(tv[k] * px + nv[k] * ht + bv[k] * pz, 24);
        len = int_sqrt(w[0] * w[0] + w[1] * w[1] + w[2] * w[2]);
        if (len == 0) begin
            d = '0;
        end else begin
            d.dx = scale_to_q14(w[0], len);
            d.dy = scale_to_q14(w[1], len);
            d.dz = scale_to_q14(w[2], len);
        end
        return d;
    endfunction

    // ---------------- stimulus ----------------
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_sample(logic [15:0] u, logic [15:0] v, basis_t b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, v, u};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_dirs.push_back(sample_direction(u, v, b));
        // next beat may keep tvalid high; only drop it when the caller goes idle
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
    endtask

    function automatic q14_t rand_comp();
        return q14_t'($urandom_range(65535));
    endfunction

    // unit-ish orthonormal basis scaled near 1.0, with random perturbation; fully random components when wild is set
    function automatic basis_t rand_basis(bit wild);
        basis_t b;
        q14_t s;
        if (wild) begin
            b = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        end else begin
            s = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            b = '0;
            case ($urandom_range(2))
                0: begin b.tx = s; b.ny = s; b.bz = s; end
                1: begin b.ty = s; b.nz = s; b.bx = s; end
                default: begin b.tz = s; b.nx = s; b.by = s; end
            endcase
            b.tx += q14_t'($signed($urandom_range(2047)) - 1024);
            b.ny += q14_t'($signed($urandom_range(2047)) - 1024);
            b.bz += q14_t'($signed($urandom_range(2047)) - 1024);
        end
        return b;
    endfunction

    task automatic test_directed();
        basis_t ident, zero, full;
        logic [15:0] uv [6] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF};
        ident = '0; ident.tx = 16'sd16384; ident.ny = 16'sd16384; ident.bz = 16'sd16384;
        zero = '0;
        full = {9{16'sh7FFF}};
        for (int i = 0; i < 6; i++) send_sample(uv[i], uv[5 - i], ident);
        send_sample(16'h1234, 16'hFFFF, zero);      // degenerate basis
        send_sample(16'h0000, 16'h0000, zero);
        send_sample(16'hFFFF, 16'hFFFF, full);
        send_sample(16'h8000, 16'h8000, {9{16'sh8000}});
        send_sample(16'h2000, 16'hFFFF, ident);     // rim: height near zero
        send_sample(16'h6000, 16'hFFFE, ident);
        send_sample(16'h0001, 16'hFFFF, {16'sh8000, 16'sh7FFF, 16'sh8000,
                                         16'sh7FFF, 16'sh8000, 16'sh7FFF,
                                         16'sh8000, 16'sh7FFF, 16'sh8000});
        send_sample(16'hAAAA, 16'h5555, {9{16'sh5555}});
        send_sample(16'h5555, 16'hAAAA, {9{16'shAAAA}});
        go_idle();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_sample(16'($urandom), 16'($urandom), rand_basis($urandom_range(3) == 0));
        go_idle();
    endtask

    task automatic drain_results();
        while (expected_dirs.size() != 0 && quiet_cycles < STALL_MAX) @(posedge aclk);
    endtask

    // ---------------- result checking and receiver stalls ----------------
    always @(posedge aclk) begin
        dir_t got, want;
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_dirs.size() == 0) begin
                report_mismatch("unexpected beat", 0, 1);
            end else begin
                want = expected_dirs.pop_front();
                if (got.dx !== want.dx) report_mismatch("dir_x", got.dx, want.dx);
                if (got.dy !== want.dy) report_mismatch("dir_y", got.dy, want.dy);
                if (got.dz !== want.dz) report_mismatch("dir_z", got.dz, want.dz);
            end
        end
    end

    // watchdog: no handshake for too long ends the run
    always @(posedge aclk) begin
        if (quiet_cycles >= STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400, 0, 0);
        drain_results();                 // sender holds off until all results are in
        test_random(300, 76, 0);
        test_random(300, 0, 76);
        test_random(300, 13, 13);
        test_random(100, 0, 0);
        drain_results();
        repeat (LATENCY + 20) @(posedge aclk);
        if (error_count == 0 && expected_dirs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
